[rtl/core/fcd_pkg.sv]
package fcd_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int CIRCLE_RADIUS = 3;
  localparam int WIN           = 2 * CIRCLE_RADIUS + 1;
  localparam int HIST          = WIN - 1;
  localparam int NPTS          = 16;
  localparam int MIN_COUNT     = 9;
  localparam int NGRP          = 4;
  localparam int GRP_SIZE      = NPTS / NGRP;

  localparam int PIX_W    = 8;
  localparam int THR_W    = 8;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int X_W      = 10;
  localparam int Y_W      = 12;
  localparam int ROW_W    = 12;
  localparam int SCORE_W  = 12;
  localparam int CNT_W    = 5;
  localparam int PART_W   = 10;

  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  localparam int OUT_QD  = 8;
  localparam int OUT_QAW = $clog2(OUT_QD);

  localparam logic [THR_W-1:0]    THRESHOLD_RST = THR_W'(20);
  localparam logic [WIDTH_W-1:0]  WIDTH_RST     = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST    = HEIGHT_W'(480);

  localparam int CIRC_DX [NPTS] = '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};
  localparam int CIRC_DY [NPTS] = '{-3, -3, -2, -1, 0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3};

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0]    intensity_threshold;
    logic [WIDTH_W-1:0]  image_width;
    logic [HEIGHT_W-1:0] image_height;
  } fcd_cfg_t;

  typedef struct packed {
    logic           valid;
    logic           eligible;
    logic [X_W-1:0] corner_x;
    logic [Y_W-1:0] corner_y;
  } fcd_ctl_t;

  typedef struct packed {
    logic [X_W-1:0]     corner_x;
    logic [Y_W-1:0]     corner_y;
    logic [SCORE_W-1:0] corner_score;
  } fcd_corner_t;

  typedef struct packed {
    logic        valid;
    fcd_corner_t corner;
  } fcd_push_t;

endpackage

[rtl/core/fcd_pixel_if.sv]
interface fcd_pixel_if import fcd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic             frame_start;

  modport source (output valid, pixel_value, frame_start, input ready);
  modport sink (input valid, pixel_value, frame_start, output ready);
endinterface

[rtl/core/fcd_corner_if.sv]
interface fcd_corner_if import fcd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [X_W-1:0]     corner_x;
  logic [Y_W-1:0]     corner_y;
  logic [SCORE_W-1:0] corner_score;

  modport source (output valid, corner_x, corner_y, corner_score, input ready);
  modport sink (input valid, corner_x, corner_y, corner_score, output ready);
endinterface

[rtl/core/fcd_cfg_regs.sv]
module fcd_cfg_regs import fcd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output fcd_cfg_t          cfg
);

  fcd_cfg_t cfg_r;
  fcd_cfg_t cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_THRESHOLD: cfg_nxt.intensity_threshold = pwdata[THR_W-1:0];
        REG_WIDTH:     cfg_nxt.image_width         = pwdata[WIDTH_W-1:0];
        REG_HEIGHT:    cfg_nxt.image_height        = pwdata[HEIGHT_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_THRESHOLD: prdata = APB_DW'(cfg_r.intensity_threshold);
      REG_WIDTH:     prdata = APB_DW'(cfg_r.image_width);
      REG_HEIGHT:    prdata = APB_DW'(cfg_r.image_height);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.intensity_threshold <= THRESHOLD_RST;
      cfg_r.image_width         <= WIDTH_RST;
      cfg_r.image_height        <= HEIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/core/fcd_line_mem.sv]
module fcd_line_mem import fcd_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_fire,
  input  logic [PIX_W-1:0]       pixel_value,
  input  logic                   frame_start,
  input  fcd_cfg_t               cfg,
  output fcd_ctl_t               s1_ctl,
  output logic [WIN*PIX_W-1:0]   colv
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int MW = HIST * PIX_W;

  logic [MW-1:0] mem [MAX_WIDTH];

  logic [CW-1:0]       col_r, col_nxt, col_base, col_now;
  logic [ROW_W-1:0]    row_r, row_nxt, row_base, row_now;
  logic [EW-1:0]       eff_w, col_inc;
  logic [HEIGHT_W-1:0] eff_h, row_inc;

  logic                s1_v_r;
  logic [CW-1:0]       s1_col_r;
  logic [PIX_W-1:0]    s1_pix_r;
  logic                s1_elig_r;
  logic [X_W-1:0]      s1_x_r;
  logic [Y_W-1:0]      s1_y_r;
  logic                fwd_r;
  logic [MW-1:0]       fwd_data_r;
  logic [MW-1:0]       rd_r;
  logic [MW-1:0]       hist;
  logic [MW-1:0]       wdata;
  logic                elig_now;

  always_comb begin
    if (cfg.image_width == '0) begin
      eff_w = EW'(1);
    end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      eff_h = HEIGHT_W'(1);
    end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
      eff_h = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      eff_h = cfg.image_height;
    end
  end

  always_comb begin
    col_base = frame_start ? '0 : col_r;
    row_base = frame_start ? '0 : row_r;
    col_now  = (EW'(col_base) >= eff_w) ? '0 : col_base;
    row_now  = (HEIGHT_W'(row_base) >= eff_h) ? '0 : row_base;
    col_inc  = EW'(col_now) + EW'(1);
    row_inc  = HEIGHT_W'(row_now) + HEIGHT_W'(1);
    col_nxt  = col_now + CW'(1);
    row_nxt  = row_now;
    if (col_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
    end
    elig_now = (32'(col_now) >= 32'(2 * CIRCLE_RADIUS))
            && (32'(row_now) >= 32'(2 * CIRCLE_RADIUS));
  end

  assign hist  = fwd_r ? fwd_data_r : rd_r;
  assign colv  = {s1_pix_r, hist};
  assign wdata = colv[WIN*PIX_W-1:PIX_W];

  assign s1_ctl.valid    = s1_v_r;
  assign s1_ctl.eligible = s1_elig_r;
  assign s1_ctl.corner_x = s1_x_r;
  assign s1_ctl.corner_y = s1_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_fire;
      if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_r       <= mem[col_now];
      fwd_r      <= s1_v_r && (s1_col_r == col_now);
      fwd_data_r <= wdata;
      s1_col_r   <= col_now;
      s1_pix_r   <= pixel_value;
      s1_elig_r  <= elig_now;
      s1_x_r     <= X_W'(32'(col_now) - 32'(CIRCLE_RADIUS));
      s1_y_r     <= Y_W'(32'(row_now) - 32'(CIRCLE_RADIUS));
    end
    if (s1_v_r) begin
      mem[s1_col_r] <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_fwd_same_col: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && fwd_r |-> $past(s1_v_r) && ($past(s1_col_r) == s1_col_r))
    else $error("forwarded history without a write to the same column");
`endif

endmodule

[rtl/core/fcd_window.sv]
module fcd_window import fcd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fcd_ctl_t             s1_ctl,
  input  logic [WIN*PIX_W-1:0] colv,
  input  logic [THR_W-1:0]     threshold,
  output fcd_push_t            push,
  output logic [1:0]           inflight
);

  logic [PIX_W-1:0] win_r [WIN][WIN];

  logic           s2_v_r;
  logic [X_W-1:0] s2_x_r;
  logic [Y_W-1:0] s2_y_r;

  logic             s3_v_r;
  logic [X_W-1:0]   s3_x_r;
  logic [Y_W-1:0]   s3_y_r;
  logic [NPTS-1:0]  s3_bright_r;
  logic [NPTS-1:0]  s3_dark_r;
  logic [PIX_W-1:0] s3_diff_r [NPTS];

  logic              s4_v_r;
  logic [X_W-1:0]    s4_x_r;
  logic [Y_W-1:0]    s4_y_r;
  logic [CNT_W-1:0]  s4_nb_r, s4_nd_r;
  logic [PART_W-1:0] s4_part_r [NGRP];

  logic [NPTS-1:0]   bright, dark;
  logic [PIX_W-1:0]  diff [NPTS];
  logic [CNT_W-1:0]  nb, nd;
  logic [PART_W-1:0] part [NGRP];
  logic [SCORE_W-1:0] score;

  always_comb begin
    logic [PIX_W:0] v, p, t;
    v = {1'b0, win_r[CIRCLE_RADIUS][CIRCLE_RADIUS]};
    t = {1'b0, threshold};
    for (int k = 0; k < NPTS; k++) begin
      p = {1'b0, win_r[CIRCLE_RADIUS + CIRC_DY[k]][CIRCLE_RADIUS + CIRC_DX[k]]};
      bright[k] = (p >= v + t);
      dark[k]   = !bright[k] && (p + t <= v);
      if (bright[k]) begin
        diff[k] = PIX_W'(p - v);
      end else if (dark[k]) begin
        diff[k] = PIX_W'(v - p);
      end else begin
        diff[k] = '0;
      end
    end
  end

  always_comb begin
    nb = '0;
    nd = '0;
    for (int k = 0; k < NPTS; k++) begin
      nb = nb + CNT_W'(s3_bright_r[k]);
      nd = nd + CNT_W'(s3_dark_r[k]);
    end
    for (int g = 0; g < NGRP; g++) begin
      part[g] = PART_W'(s3_diff_r[g*GRP_SIZE]) + PART_W'(s3_diff_r[g*GRP_SIZE+1])
              + PART_W'(s3_diff_r[g*GRP_SIZE+2]) + PART_W'(s3_diff_r[g*GRP_SIZE+3]);
    end
  end

  assign score = (SCORE_W'(s4_part_r[0]) + SCORE_W'(s4_part_r[1]))
               + (SCORE_W'(s4_part_r[2]) + SCORE_W'(s4_part_r[3]));

  assign push.valid = s4_v_r && ((s4_nb_r >= CNT_W'(MIN_COUNT))
                              || (s4_nd_r >= CNT_W'(MIN_COUNT)));
  assign push.corner.corner_x     = s4_x_r;
  assign push.corner.corner_y     = s4_y_r;
  assign push.corner.corner_score = score;

  assign inflight = 2'(s2_v_r) + 2'(s3_v_r) + 2'(s4_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < WIN; r++) begin
        for (int c = 0; c < WIN; c++) begin
          win_r[r][c] <= '0;
        end
      end
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s1_ctl.valid) begin
        for (int r = 0; r < WIN; r++) begin
          for (int c = 0; c < WIN - 1; c++) begin
            win_r[r][c] <= win_r[r][c+1];
          end
          win_r[r][WIN-1] <= colv[r*PIX_W +: PIX_W];
        end
      end
      s2_v_r <= s1_ctl.valid && s1_ctl.eligible;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_x_r      <= s1_ctl.corner_x;
    s2_y_r      <= s1_ctl.corner_y;
    s3_x_r      <= s2_x_r;
    s3_y_r      <= s2_y_r;
    s3_bright_r <= bright;
    s3_dark_r   <= dark;
    for (int k = 0; k < NPTS; k++) begin
      s3_diff_r[k] <= diff[k];
    end
    s4_x_r  <= s3_x_r;
    s4_y_r  <= s3_y_r;
    s4_nb_r <= nb;
    s4_nd_r <= nd;
    for (int g = 0; g < NGRP; g++) begin
      s4_part_r[g] <= part[g];
    end
  end

endmodule

[rtl/core/fcd_out_queue.sv]
module fcd_out_queue import fcd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  fcd_push_t        push,
  input  logic             out_ready,
  output logic             out_valid,
  output fcd_corner_t      out_data,
  output logic [OUT_QAW:0] count
);

  fcd_corner_t        q_r [OUT_QD];
  logic [OUT_QAW-1:0] head_r, tail_r;
  logic [OUT_QAW:0]   count_r, count_nxt;
  logic               pop;

  assign out_valid = (count_r != '0);
  assign out_data  = q_r[head_r];
  assign pop       = out_valid && out_ready;
  assign count     = count_r;

  always_comb begin
    count_nxt = count_r;
    if (push.valid && !pop) begin
      count_nxt = count_r + (OUT_QAW+1)'(1);
    end else if (!push.valid && pop) begin
      count_nxt = count_r - (OUT_QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push.valid) begin
        tail_r <= tail_r + OUT_QAW'(1);
      end
      if (pop) begin
        head_r <= head_r + OUT_QAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      q_r[tail_r] <= push.corner;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid && !pop |-> count_r != (OUT_QAW+1)'(OUT_QD))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (OUT_QAW+1)'(OUT_QD))
    else $error("result queue count out of range");
`endif

endmodule

[rtl/core/fast_corner_detect.sv]
// Path: a corner whose 7x7 window is completed by an accepted request passes the line
// stage, window stages s2, s3 and s4 and the result queue before it is offered on out_corner.
// Throughput: one pixel request per cycle; ready follows a credit count of an
// 8-entry result queue against the four pipeline stages in flight.
// Reset: synchronous, active low; clears position counters, window, pipeline
// valids, result queue and registers. The line memory is not cleared.
module fast_corner_detect import fcd_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  fcd_pixel_if.sink         in_pix,
  fcd_corner_if.source      out_corner,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  fcd_cfg_t           cfg;
  fcd_ctl_t           s1_ctl;
  logic [WIN*PIX_W-1:0] colv;
  fcd_push_t          push;
  logic [1:0]         inflight;
  logic [OUT_QAW:0]   qcount;
  fcd_corner_t        out_data;
  logic               in_fire;
  logic [OUT_QAW+1:0] credit_used;

  assign credit_used  = (OUT_QAW+2)'(qcount) + (OUT_QAW+2)'(s1_ctl.valid)
                      + (OUT_QAW+2)'(inflight);
  assign in_pix.ready = (credit_used < (OUT_QAW+2)'(OUT_QD));
  assign in_fire      = in_pix.valid && in_pix.ready;

  fcd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fcd_line_mem #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_mem (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .pixel_value (in_pix.pixel_value),
    .frame_start (in_pix.frame_start),
    .cfg         (cfg),
    .s1_ctl      (s1_ctl),
    .colv        (colv)
  );

  fcd_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_ctl    (s1_ctl),
    .colv      (colv),
    .threshold (cfg.intensity_threshold),
    .push      (push),
    .inflight  (inflight)
  );

  fcd_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_ready (out_corner.ready),
    .out_valid (out_corner.valid),
    .out_data  (out_data),
    .count     (qcount)
  );

  assign out_corner.corner_x     = out_data.corner_x;
  assign out_corner.corner_y     = out_data.corner_y;
  assign out_corner.corner_score = out_data.corner_score;

`ifndef SYNTHESIS
  a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_ctl.valid)
    else $error("accepted pixel did not enter the line stage");

  a_credit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> qcount < (OUT_QAW+1)'(OUT_QD) || out_corner.ready)
    else $error("corner pushed while result queue full");
`endif

endmodule
